// ===== rtl/stack_vm_instruction_executor_assert.svh =====
// assertion macros for the stack machine executor checker
// depends on clk and rst_n being visible where the macros are used
`ifndef STACK_VM_INSTRUCTION_EXECUTOR_ASSERT_SVH
`define STACK_VM_INSTRUCTION_EXECUTOR_ASSERT_SVH

// same-cycle implication
`define SVIE_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SVIE_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/svie_pkg.sv =====
// shared types, opcodes and sizes of the stack machine executor
// no dependencies
package svie_pkg;

  localparam int STACK_DEPTH = 128;
  localparam int ARG_DEPTH   = 256;
  localparam int CODE_DEPTH  = 1024;
  localparam int DATA_WIDTH  = 32;

  localparam int SW  = $clog2(STACK_DEPTH);
  localparam int TW  = SW + 1;
  localparam int AW  = $clog2(ARG_DEPTH);
  localparam int ATW = AW + 1;
  localparam int CW  = $clog2(CODE_DEPTH);
  localparam int XW  = 34;

  localparam logic [1:0] CFG_GVC = 2'd0;
  localparam logic [1:0] CFG_ICS = 2'd1;
  localparam logic [1:0] CFG_ICL = 2'd2;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_DIV0  = 2'd1;
  localparam logic [1:0] ERR_BOUND = 2'd2;
  localparam logic [1:0] ERR_OPC   = 2'd3;

  typedef enum logic [4:0] {
    OP_LOAD = 5'd0, OP_LOADI = 5'd1, OP_STO = 5'd2, OP_STI = 5'd3,
    OP_ADD = 5'd4, OP_SUB = 5'd5, OP_MULT = 5'd6, OP_DIV = 5'd7,
    OP_BR = 5'd8, OP_BRF = 5'd9, OP_EQ = 5'd10, OP_NOTEQ = 5'd11,
    OP_GT = 5'd12, OP_LES = 5'd13, OP_GE = 5'd14, OP_LE = 5'd15,
    OP_AND = 5'd16, OP_OR = 5'd17, OP_NOT = 5'd18, OP_IN = 5'd19,
    OP_OUT = 5'd20, OP_RETURN = 5'd21, OP_ENTER = 5'd22, OP_CAL = 5'd23,
    OP_LOADA = 5'd24, OP_STOA = 5'd25, OP_PUSH = 5'd26, OP_POP = 5'd27,
    OP_START = 5'd28
  } op_t;

  typedef struct packed {
    logic [4:0]         operation;
    logic signed [31:0] operand;
    logic signed [31:0] in_value;
  } in_t;

  typedef struct packed {
    logic [9:0]         next_address;
    logic               out_valid;
    logic signed [31:0] out_value;
    logic               halted;
    logic [1:0]         error_code;
  } out_t;

endpackage

// ===== rtl/stack_vm_instruction_executor.sv =====
// top level of the p-code stack machine executor
// depends on svie_pkg, svie_ram, svie_div
//
//  channel  direction  payload  handshake
//  in_      input      in_t     in_valid / in_stall
//  out_     output     out_t    out_valid / out_stall
//  cfg_     input      10 bit   cfg_we, no wait
//
// one instruction at a time: after the input beat the block steps through DEC, RD2, EXEC,
// WR and FIN to the result beat, with WR2 for CAL and START when they write two stack
// words and DIV for DIV (one quotient bit per cycle). the single stack ram read port
// sets the two read states DEC and RD2. a new beat is taken only once the result beat
// has left. reset is synchronous; the stack memories need no clearing.
module stack_vm_instruction_executor (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  svie_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output svie_pkg::out_t  out_data,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_index,
  input  logic [9:0]      cfg_data
);

  localparam int DW  = svie_pkg::DATA_WIDTH;
  localparam int SW  = svie_pkg::SW;
  localparam int TW  = svie_pkg::TW;
  localparam int AW  = svie_pkg::AW;
  localparam int ATW = svie_pkg::ATW;
  localparam int CW  = svie_pkg::CW;
  localparam int XW  = svie_pkg::XW;

  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001,
    S_DEC  = 8'b00000010,
    S_RD2  = 8'b00000100,
    S_EXEC = 8'b00001000,
    S_DIV  = 8'b00010000,
    S_WR   = 8'b00100000,
    S_WR2  = 8'b01000000,
    S_FIN  = 8'b10000000
  } state_t;

  state_t state_r;

  logic [6:0]    gvc_r;
  logic [9:0]    ics_r, icl_r;
  logic [4:0]    op_r;
  logic [31:0]   opnd_r, inv_r;
  logic [TW-1:0] top_r;
  logic [SW-1:0] base_r;
  logic [CW-1:0] ip_r, ipt_r;
  logic [ATW-1:0] atop_r;
  logic          init_r, start_r;
  logic [DW-1:0] a_r;
  logic [1:0]    err_r;
  logic          ov_r;
  logic [DW-1:0] oval_r;
  logic          we1_r, we2_r, awe_r;
  logic [SW-1:0] wa1_r, wa2_r;
  logic [DW-1:0] wd1_r, wd2_r;
  logic [AW-1:0] awa_r;
  logic          out_valid_r;
  svie_pkg::out_t out_r;

  logic          stk_we;
  logic [SW-1:0] stk_waddr, stk_raddr;
  logic [DW-1:0] stk_wdata, b;
  logic [DW-1:0] arg_rdata;
  logic          div_start, div_done;
  logic [DW-1:0] div_q;

  svie_ram #(.WIDTH(DW), .DEPTH(svie_pkg::STACK_DEPTH)) u_stk (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(b)
  );

  svie_ram #(.WIDTH(DW), .DEPTH(svie_pkg::ARG_DEPTH)) u_arg (
    .clk(clk), .we(awe_r && state_r == S_WR), .waddr(awa_r), .wdata(wd2_r),
    .raddr(AW'(atop_r - 1'b1)), .rdata(arg_rdata)
  );

  svie_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(a_r), .den(b),
    .done(div_done), .quo(div_q)
  );

  // decode from captured instruction
  logic signed [XW-1:0] off, lsum, esum;
  logic [10:0] nb;
  logic        is_bin, ld_ok;
  logic [1:0]  pre_err;
  logic [SW-1:0] ra1, ra2;

  always_comb begin
    off  = XW'($signed(opnd_r));
    lsum = off + ((op_r == svie_pkg::OP_LOAD || op_r == svie_pkg::OP_STO) ?
                  $signed({{(XW-SW){1'b0}}, base_r}) : XW'(0));
    esum = $signed({{(XW-TW){1'b0}}, top_r}) + off;
    nb   = 11'(gvc_r) + 11'(icl_r);
    ld_ok = !lsum[XW-1] && lsum < XW'(svie_pkg::STACK_DEPTH);
    is_bin = 1'b0;
    pre_err = svie_pkg::ERR_NONE;
    case (op_r) inside
      [svie_pkg::OP_ADD:svie_pkg::OP_DIV], [svie_pkg::OP_EQ:svie_pkg::OP_OR]: begin
        is_bin = 1'b1;
        if (top_r < TW'(2)) pre_err = svie_pkg::ERR_BOUND;
      end
      svie_pkg::OP_LOAD, svie_pkg::OP_LOADA: begin
        if (top_r >= TW'(svie_pkg::STACK_DEPTH) || !ld_ok) pre_err = svie_pkg::ERR_BOUND;
      end
      svie_pkg::OP_LOADI, svie_pkg::OP_IN: begin
        if (top_r >= TW'(svie_pkg::STACK_DEPTH)) pre_err = svie_pkg::ERR_BOUND;
      end
      svie_pkg::OP_STO, svie_pkg::OP_STOA: begin
        if (top_r == '0 || !ld_ok) pre_err = svie_pkg::ERR_BOUND;
      end
      svie_pkg::OP_BRF, svie_pkg::OP_NOT, svie_pkg::OP_OUT: begin
        if (top_r == '0) pre_err = svie_pkg::ERR_BOUND;
      end
      svie_pkg::OP_RETURN: begin
        if (TW'(base_r) + TW'(2) > TW'(svie_pkg::STACK_DEPTH)) pre_err = svie_pkg::ERR_BOUND;
      end
      svie_pkg::OP_ENTER: begin
        if (esum[XW-1] || esum > XW'(svie_pkg::STACK_DEPTH)) pre_err = svie_pkg::ERR_BOUND;
      end
      svie_pkg::OP_CAL: begin
        if (top_r + TW'(2) > TW'(svie_pkg::STACK_DEPTH) || top_r[TW-1])
          pre_err = svie_pkg::ERR_BOUND;
      end
      svie_pkg::OP_PUSH: begin
        if (top_r == '0 || atop_r >= ATW'(svie_pkg::ARG_DEPTH)) pre_err = svie_pkg::ERR_BOUND;
      end
      svie_pkg::OP_POP: begin
        if (top_r >= TW'(svie_pkg::STACK_DEPTH) || atop_r == '0) pre_err = svie_pkg::ERR_BOUND;
      end
      svie_pkg::OP_START: begin
        if (12'(nb) + 12'd2 > 12'(svie_pkg::STACK_DEPTH)) pre_err = svie_pkg::ERR_BOUND;
      end
      svie_pkg::OP_STI, svie_pkg::OP_BR: pre_err = svie_pkg::ERR_NONE;
      default: pre_err = svie_pkg::ERR_OPC;
    endcase
    ra1 = (op_r == svie_pkg::OP_RETURN) ? base_r : SW'(top_r - TW'(2));
    case (op_r)
      svie_pkg::OP_LOAD, svie_pkg::OP_LOADA: ra2 = lsum[SW-1:0];
      svie_pkg::OP_RETURN: ra2 = SW'(base_r + 1'b1);
      default: ra2 = SW'(top_r - 1'b1);
    endcase
  end

  assign stk_raddr = (state_r == S_DEC) ? ra1 : ra2;

  // execute, a_r and b hold the two reads
  logic [DW-1:0] res;
  logic          x_we1, x_we2, x_awe, x_div, x_init, x_ov;
  logic [SW-1:0] x_wa1, x_wa2;
  logic [DW-1:0] x_wd1, x_wd2, x_oval;
  logic [TW-1:0] x_top;
  logic [SW-1:0] x_base;
  logic [CW-1:0] x_ip;
  logic [ATW-1:0] x_atop;
  logic [1:0]    x_err;

  always_comb begin
    case (op_r)
      svie_pkg::OP_ADD:   res = a_r + b;
      svie_pkg::OP_SUB:   res = a_r - b;
      svie_pkg::OP_MULT:  res = a_r * b;
      svie_pkg::OP_EQ:    res = DW'(a_r == b);
      svie_pkg::OP_NOTEQ: res = DW'(a_r != b);
      svie_pkg::OP_GT:    res = DW'($signed(b) < $signed(a_r));
      svie_pkg::OP_LES:   res = DW'($signed(a_r) < $signed(b));
      svie_pkg::OP_GE:    res = DW'(!($signed(a_r) < $signed(b)));
      svie_pkg::OP_LE:    res = DW'(!($signed(b) < $signed(a_r)));
      svie_pkg::OP_AND:   res = DW'(a_r != '0 && b != '0);
      svie_pkg::OP_OR:    res = DW'(a_r != '0 || b != '0);
      default:            res = '0;
    endcase
    x_we1 = 1'b0; x_we2 = 1'b0; x_awe = 1'b0; x_div = 1'b0; x_ov = 1'b0;
    x_wa1 = SW'(top_r); x_wa2 = SW'(top_r + 1'b1);
    x_wd1 = '0; x_wd2 = '0; x_oval = '0;
    x_top = top_r; x_base = base_r; x_atop = atop_r; x_init = init_r;
    x_ip = CW'(ip_r + 1'b1);
    x_err = pre_err;
    if (pre_err == svie_pkg::ERR_NONE) begin
      if (is_bin) begin
        x_wa1 = SW'(top_r - TW'(2));
        x_wd1 = res;
        x_top = top_r - 1'b1;
        x_we1 = 1'b1;
        if (op_r == svie_pkg::OP_DIV) begin
          if (b == '0) x_err = svie_pkg::ERR_DIV0;
          else x_div = 1'b1;
        end
      end else begin
        case (op_r)
          svie_pkg::OP_LOAD, svie_pkg::OP_LOADA: begin
            x_we1 = 1'b1; x_wd1 = b; x_top = top_r + 1'b1;
          end
          svie_pkg::OP_LOADI: begin
            x_we1 = 1'b1; x_wd1 = DW'($signed(opnd_r)); x_top = top_r + 1'b1;
          end
          svie_pkg::OP_IN: begin
            x_we1 = 1'b1; x_wd1 = DW'($signed(inv_r)); x_top = top_r + 1'b1;
          end
          svie_pkg::OP_STO, svie_pkg::OP_STOA: begin
            x_we1 = 1'b1; x_wa1 = lsum[SW-1:0]; x_wd1 = b; x_top = top_r - 1'b1;
          end
          svie_pkg::OP_BR: x_ip = opnd_r[CW-1:0];
          svie_pkg::OP_BRF: begin
            x_top = top_r - 1'b1;
            if (b == '0) x_ip = opnd_r[CW-1:0];
          end
          svie_pkg::OP_NOT: begin
            x_we1 = 1'b1; x_wa1 = SW'(top_r - 1'b1); x_wd1 = DW'(b == '0);
          end
          svie_pkg::OP_OUT: begin
            x_top = top_r - 1'b1; x_ov = 1'b1; x_oval = b;
          end
          svie_pkg::OP_RETURN: begin
            if ((a_r >> SW) != '0) begin
              x_err = svie_pkg::ERR_BOUND;
            end else begin
              x_top = TW'(base_r); x_ip = b[CW-1:0]; x_base = a_r[SW-1:0];
            end
          end
          svie_pkg::OP_ENTER: x_top = esum[TW-1:0];
          svie_pkg::OP_CAL: begin
            x_we1 = 1'b1; x_wd1 = DW'(base_r);
            x_we2 = 1'b1; x_wd2 = DW'(x_ip);
            x_base = SW'(top_r); x_ip = opnd_r[CW-1:0];
          end
          svie_pkg::OP_PUSH: begin
            x_awe = 1'b1; x_wd2 = b; x_atop = atop_r + 1'b1;
          end
          svie_pkg::OP_POP: begin
            x_we1 = 1'b1; x_wd1 = arg_rdata;
            x_top = top_r + 1'b1; x_atop = atop_r - 1'b1;
          end
          svie_pkg::OP_START: begin
            x_we1 = 1'b1; x_wa1 = nb[SW-1:0];
            x_we2 = 1'b1; x_wa2 = SW'(nb + 1'b1);
            x_base = nb[SW-1:0]; x_top = TW'(gvc_r); x_init = 1'b1;
            x_ip = ics_r[CW-1:0];
          end
          default: x_top = top_r;
        endcase
      end
    end else if (op_r == svie_pkg::OP_START) begin
      x_ip = ip_r;
    end
  end

  assign div_start = (state_r == S_EXEC) && x_div;

  always_comb begin
    stk_we    = 1'b0;
    stk_waddr = wa1_r;
    stk_wdata = wd1_r;
    if (state_r == S_WR) begin
      stk_we = we1_r;
    end else if (state_r == S_WR2) begin
      stk_we = we2_r; stk_waddr = wa2_r; stk_wdata = wd2_r;
    end
  end

  logic [10:0] init_end;
  assign init_end = 11'(ics_r) + 11'(icl_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      gvc_r       <= '0;
      ics_r       <= '0;
      icl_r       <= '0;
      top_r       <= '0;
      base_r      <= '0;
      ip_r        <= '0;
      atop_r      <= '0;
      init_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          svie_pkg::CFG_GVC: gvc_r <= cfg_data[6:0];
          svie_pkg::CFG_ICS: ics_r <= cfg_data;
          svie_pkg::CFG_ICL: icl_r <= cfg_data;
          default: gvc_r <= gvc_r;
        endcase
      end
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid && !in_stall) state_r <= S_DEC;
        end
        S_DEC: state_r <= S_RD2;
        S_RD2: state_r <= S_EXEC;
        S_EXEC: begin
          top_r  <= x_top;
          base_r <= x_base;
          atop_r <= x_atop;
          init_r <= x_init;
          state_r <= x_div ? S_DIV : S_WR;
        end
        S_DIV: begin
          if (div_done) state_r <= S_WR;
        end
        S_WR: state_r <= we2_r ? S_WR2 : S_FIN;
        S_WR2: state_r <= S_FIN;
        S_FIN: begin
          out_valid_r <= 1'b1;
          state_r <= S_IDLE;
          if (!(!start_r && ipt_r == '0) && init_r && 11'(ipt_r) == init_end) begin
            init_r <= 1'b0;
            top_r  <= TW'(base_r);
            ip_r   <= '0;
          end else begin
            ip_r <= ipt_r;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
    if (state_r == S_IDLE && in_valid && !in_stall) begin
      op_r   <= in_data.operation;
      opnd_r <= in_data.operand;
      inv_r  <= in_data.in_value;
    end
    if (state_r == S_RD2) a_r <= b;
    if (state_r == S_EXEC) begin
      we1_r <= x_we1; wa1_r <= x_wa1; wd1_r <= x_wd1;
      we2_r <= x_we2; wa2_r <= x_wa2; wd2_r <= x_wd2;
      awe_r <= x_awe; awa_r <= atop_r[AW-1:0];
      ipt_r <= x_ip; err_r <= x_err; ov_r <= x_ov; oval_r <= x_oval;
      start_r <= (op_r == svie_pkg::OP_START);
    end
    if (state_r == S_DIV && div_done) wd1_r <= div_q;
    if (state_r == S_FIN) begin
      out_r.out_valid  <= ov_r;
      out_r.out_value  <= ov_r ? 32'($signed(oval_r)) : '0;
      out_r.error_code <= err_r;
      out_r.halted     <= !start_r && ipt_r == '0;
      if (!(!start_r && ipt_r == '0) && init_r && 11'(ipt_r) == init_end)
        out_r.next_address <= '0;
      else
        out_r.next_address <= 10'(ipt_r);
    end
  end

  assign in_stall  = (state_r != S_IDLE) || out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== rtl/svie_ram.sv =====
// generic simple dual-port ram, one write and one registered read
// no dependencies
module svie_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/svie_div.sv =====
// iterative signed divider, one quotient bit per cycle
// depends on svie_pkg
module svie_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [svie_pkg::DATA_WIDTH-1:0]  num,
  input  logic [svie_pkg::DATA_WIDTH-1:0]  den,
  output logic                             done,
  output logic [svie_pkg::DATA_WIDTH-1:0]  quo
);

  localparam int DW = svie_pkg::DATA_WIDTH;
  localparam int NW = $clog2(DW + 1);

  logic          busy_r, busy_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;
  logic          neg_r, neg_nxt;
  logic [DW:0]   rem_r, rem_nxt;
  logic [DW-1:0] q_r, q_nxt;
  logic [DW-1:0] den_r, den_nxt;
  logic          done_r, done_nxt;
  logic [DW:0]   rem_sh;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    den_nxt  = den_r;
    done_nxt = 1'b0;
    rem_sh   = {rem_r[DW-1:0], q_r[DW-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = NW'(DW);
      neg_nxt  = num[DW-1] ^ den[DW-1];
      rem_nxt  = '0;
      q_nxt    = num[DW-1] ? (~num + 1'b1) : num;
      den_nxt  = den[DW-1] ? (~den + 1'b1) : den;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, den_r}) begin
        rem_nxt = rem_sh - {1'b0, den_r};
        q_nxt   = {q_r[DW-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        q_nxt   = {q_r[DW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == NW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    neg_r <= neg_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = neg_r ? (~q_r + 1'b1) : q_r;

endmodule

// ===== rtl/svie_checker.sv =====
// port-level checker for the stack machine executor, bound to the top level
// depends on svie_pkg and stack_vm_instruction_executor_assert.svh
`include "stack_vm_instruction_executor_assert.svh"

module svie_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_stall,
  input logic           out_valid,
  input logic           out_stall,
  input svie_pkg::out_t out_data
);

  `SVIE_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "result beat dropped")
  `SVIE_NEXT(a_busy, in_valid && !in_stall, in_stall, "second beat taken while busy")
  `SVIE_IMPLY(a_halt_addr, out_valid && out_data.halted, out_data.next_address == '0, "halt address")
  `SVIE_IMPLY(a_out_zero, out_valid && !out_data.out_valid, out_data.out_value == '0, "stale data")

endmodule

bind stack_vm_instruction_executor svie_checker u_svie_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);

// ===== sim/stack_vm_instruction_executor_tb.sv =====
// self-checking testbench for the p-code stack machine executor
// needs svie_pkg and the rtl of stack_vm_instruction_executor; predicts every result beat
`timescale 1ns / 1ps

module stack_vm_instruction_executor_tb;

  localparam int LIMIT = 600000;
  localparam int NPHASE = 7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  svie_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  svie_pkg::out_t out_data;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = svie_pkg::CFG_GVC;
  logic [9:0] cfg_data = '0;

  stack_vm_instruction_executor u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // machine state as predicted
  logic [31:0] m_stk [svie_pkg::STACK_DEPTH];
  bit m_stw [svie_pkg::STACK_DEPTH];
  logic [31:0] m_arg [svie_pkg::ARG_DEPTH];
  bit m_agw [svie_pkg::ARG_DEPTH];
  int m_base = 0, m_top = 0, m_ip = 0, m_at = 0;
  bit m_pend = 1'b1;
  int m_gvc = 0, m_ics = 0, m_icl = 0;

  svie_pkg::in_t instr_q[$];
  svie_pkg::out_t exp_res[$];
  int n_err = 0, n_acc = 0, n_res = 0, n_halt = 0, n_fault = 0, n_outw = 0;
  int cycles = 0;
  bit in_fire = 1'b0;
  bit calm = 1'b0;
  int dgap = 0, sgap = 0, hold = 0;
  bit long_done = 1'b0;

  function automatic svie_pkg::out_t exec_instr(svie_pkg::in_t it);
    svie_pkg::out_t r;
    int top, base, nip, nb;
    logic [1:0] err;
    bit ov, chk;
    logic [31:0] oval, a, b, rv;
    longint addr, q;
    top = m_top;
    base = m_base;
    err = svie_pkg::ERR_NONE;
    ov = 1'b0;
    oval = '0;
    chk = 1'b1;
    if (it.operation == svie_pkg::OP_START) begin
      chk = 1'b0;
      nb = m_gvc + m_icl;
      if (nb + 2 > svie_pkg::STACK_DEPTH) begin
        nip = m_ip;
        err = svie_pkg::ERR_BOUND;
      end else begin
        m_stk[nb] = '0;
        m_stk[nb+1] = '0;
        m_stw[nb] = 1'b1;
        m_stw[nb+1] = 1'b1;
        m_base = nb;
        m_top = m_gvc;
        m_pend = 1'b1;
        nip = m_ics % svie_pkg::CODE_DEPTH;
      end
    end else begin
      nip = (m_ip + 1) % svie_pkg::CODE_DEPTH;
      case (it.operation)
        svie_pkg::OP_LOAD, svie_pkg::OP_LOADA: begin
          addr = longint'(it.operand) + ((it.operation == svie_pkg::OP_LOAD) ? base : 0);
          if (top >= svie_pkg::STACK_DEPTH || addr < 0 || addr >= svie_pkg::STACK_DEPTH)
            err = svie_pkg::ERR_BOUND;
          else begin
            m_stk[top] = m_stk[addr];
            m_stw[top] = 1'b1;
            top++;
          end
        end
        svie_pkg::OP_LOADI, svie_pkg::OP_IN: begin
          if (top >= svie_pkg::STACK_DEPTH) err = svie_pkg::ERR_BOUND;
          else begin
            m_stk[top] = (it.operation == svie_pkg::OP_LOADI) ? it.operand : it.in_value;
            m_stw[top] = 1'b1;
            top++;
          end
        end
        svie_pkg::OP_STO, svie_pkg::OP_STOA: begin
          addr = longint'(it.operand) + ((it.operation == svie_pkg::OP_STO) ? base : 0);
          if (top < 1 || addr < 0 || addr >= svie_pkg::STACK_DEPTH) err = svie_pkg::ERR_BOUND;
          else begin
            top--;
            m_stk[addr] = m_stk[top];
            m_stw[addr] = 1'b1;
          end
        end
        svie_pkg::OP_STI: ;
        svie_pkg::OP_ADD, svie_pkg::OP_SUB, svie_pkg::OP_MULT, svie_pkg::OP_DIV,
        svie_pkg::OP_EQ, svie_pkg::OP_NOTEQ, svie_pkg::OP_GT, svie_pkg::OP_LES,
        svie_pkg::OP_GE, svie_pkg::OP_LE, svie_pkg::OP_AND, svie_pkg::OP_OR: begin
          if (top < 2) err = svie_pkg::ERR_BOUND;
          else begin
            a = m_stk[top-2];
            b = m_stk[top-1];
            case (it.operation)
              svie_pkg::OP_ADD: rv = a + b;
              svie_pkg::OP_SUB: rv = a - b;
              svie_pkg::OP_MULT: rv = a * b;
              svie_pkg::OP_DIV: begin
                if (b == 0) begin
                  rv = '0;
                  err = svie_pkg::ERR_DIV0;
                end else begin
                  q = longint'($signed(a)) / longint'($signed(b));
                  rv = q[31:0];
                end
              end
              svie_pkg::OP_EQ: rv = {31'b0, a == b};
              svie_pkg::OP_NOTEQ: rv = {31'b0, a != b};
              svie_pkg::OP_GT: rv = {31'b0, $signed(a) > $signed(b)};
              svie_pkg::OP_LES: rv = {31'b0, $signed(a) < $signed(b)};
              svie_pkg::OP_GE: rv = {31'b0, $signed(a) >= $signed(b)};
              svie_pkg::OP_LE: rv = {31'b0, $signed(a) <= $signed(b)};
              svie_pkg::OP_AND: rv = {31'b0, a != 0 && b != 0};
              default: rv = {31'b0, a != 0 || b != 0};
            endcase
            m_stk[top-2] = rv;
            top--;
          end
        end
        svie_pkg::OP_BR: nip = int'(it.operand[9:0]);
        svie_pkg::OP_BRF: begin
          if (top < 1) err = svie_pkg::ERR_BOUND;
          else begin
            top--;
            if (m_stk[top] == 0) nip = int'(it.operand[9:0]);
          end
        end
        svie_pkg::OP_NOT: begin
          if (top < 1) err = svie_pkg::ERR_BOUND;
          else m_stk[top-1] = {31'b0, m_stk[top-1] == 0};
        end
        svie_pkg::OP_OUT: begin
          if (top < 1) err = svie_pkg::ERR_BOUND;
          else begin
            top--;
            ov = 1'b1;
            oval = m_stk[top];
          end
        end
        svie_pkg::OP_RETURN: begin
          if (base + 2 > svie_pkg::STACK_DEPTH || m_stk[base] >= svie_pkg::STACK_DEPTH)
            err = svie_pkg::ERR_BOUND;
          else begin
            top = base;
            nip = int'(m_stk[base+1][9:0]);
            base = m_stk[top];
          end
        end
        svie_pkg::OP_ENTER: begin
          addr = longint'(top) + longint'(it.operand);
          if (addr < 0 || addr > svie_pkg::STACK_DEPTH) err = svie_pkg::ERR_BOUND;
          else top = int'(addr);
        end
        svie_pkg::OP_CAL: begin
          if (top + 2 > svie_pkg::STACK_DEPTH) err = svie_pkg::ERR_BOUND;
          else begin
            m_stk[top] = base;
            m_stk[top+1] = nip;
            m_stw[top] = 1'b1;
            m_stw[top+1] = 1'b1;
            base = top;
            nip = int'(it.operand[9:0]);
          end
        end
        svie_pkg::OP_PUSH: begin
          if (top < 1 || m_at >= svie_pkg::ARG_DEPTH) err = svie_pkg::ERR_BOUND;
          else begin
            m_arg[m_at] = m_stk[top-1];
            m_agw[m_at] = 1'b1;
            m_at++;
          end
        end
        svie_pkg::OP_POP: begin
          if (top >= svie_pkg::STACK_DEPTH || m_at < 1) err = svie_pkg::ERR_BOUND;
          else begin
            m_at--;
            m_stk[top] = m_arg[m_at];
            m_stw[top] = 1'b1;
            top++;
          end
        end
        default: err = svie_pkg::ERR_OPC;
      endcase
      m_top = top;
      m_base = base;
    end
    m_ip = nip;
    r = '0;
    if (chk && nip == 0) r.halted = 1'b1;
    else if (m_pend && nip == m_ics + m_icl) begin
      m_pend = 1'b0;
      m_top = m_base;
      m_ip = 0;
    end
    r.next_address = m_ip[9:0];
    r.out_valid = ov;
    r.out_value = ov ? oval : '0;
    r.error_code = err;
    return r;
  endfunction

  // true when the instruction would read a stack or argument slot never written
  function automatic bit touches_unwritten(svie_pkg::in_t it);
    longint addr;
    int top;
    top = m_top;
    case (it.operation)
      svie_pkg::OP_LOAD, svie_pkg::OP_LOADA: begin
        addr = longint'(it.operand) + ((it.operation == svie_pkg::OP_LOAD) ? m_base : 0);
        return top < svie_pkg::STACK_DEPTH && addr >= 0 && addr < svie_pkg::STACK_DEPTH
               && !m_stw[addr];
      end
      svie_pkg::OP_STO, svie_pkg::OP_STOA: begin
        addr = longint'(it.operand) + ((it.operation == svie_pkg::OP_STO) ? m_base : 0);
        return top >= 1 && addr >= 0 && addr < svie_pkg::STACK_DEPTH && !m_stw[top-1];
      end
      svie_pkg::OP_ADD, svie_pkg::OP_SUB, svie_pkg::OP_MULT, svie_pkg::OP_DIV,
      svie_pkg::OP_EQ, svie_pkg::OP_NOTEQ, svie_pkg::OP_GT, svie_pkg::OP_LES,
      svie_pkg::OP_GE, svie_pkg::OP_LE, svie_pkg::OP_AND, svie_pkg::OP_OR:
        return top >= 2 && (!m_stw[top-2] || !m_stw[top-1]);
      svie_pkg::OP_BRF, svie_pkg::OP_NOT, svie_pkg::OP_OUT:
        return top >= 1 && !m_stw[top-1];
      svie_pkg::OP_PUSH:
        return top >= 1 && m_at < svie_pkg::ARG_DEPTH && !m_stw[top-1];
      svie_pkg::OP_POP:
        return top < svie_pkg::STACK_DEPTH && m_at >= 1 && !m_agw[m_at-1];
      svie_pkg::OP_RETURN:
        return m_base + 2 <= svie_pkg::STACK_DEPTH && (!m_stw[m_base] || !m_stw[m_base+1]);
      default: return 1'b0;
    endcase
  endfunction

  function automatic svie_pkg::in_t mk(logic [4:0] op, logic [31:0] opnd, logic [31:0] v);
    svie_pkg::in_t it;
    it.operation = op;
    it.operand = opnd;
    it.in_value = v;
    return it;
  endfunction

  function automatic svie_pkg::in_t rand_instr();
    svie_pkg::in_t it;
    int r;
    r = $urandom_range(0, 99);
    it.in_value = $urandom;
    if (r < 3) it.operation = 5'($urandom_range(29, 31));
    else if (r < 6) it.operation = svie_pkg::OP_START;
    else if (r < 22)
      it.operation = ($urandom_range(0, 1) != 0) ? svie_pkg::OP_LOADI : svie_pkg::OP_IN;
    else it.operation = 5'($urandom_range(0, 27));
    if ($urandom_range(0, 9) == 0) it.operand = $urandom;
    else begin
      case (it.operation)
        svie_pkg::OP_LOAD, svie_pkg::OP_STO: it.operand = $urandom_range(0, 24) - 4;
        svie_pkg::OP_LOADA, svie_pkg::OP_STOA: it.operand = $urandom_range(0, 135) - 4;
        svie_pkg::OP_ENTER: it.operand = $urandom_range(0, 8) - 3;
        svie_pkg::OP_LOADI:
          it.operand = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 3) : $urandom;
        default: it.operand = $urandom_range(0, svie_pkg::CODE_DEPTH - 1);
      endcase
    end
    return it;
  endfunction

  task automatic queue_instr(svie_pkg::in_t it);
    if (!touches_unwritten(it)) begin
      exp_res.push_back(exec_instr(it));
      instr_q.push_back(it);
    end
  endtask

  task automatic cfg_write(logic [1:0] idx, int val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[9:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      svie_pkg::CFG_GVC: m_gvc = val & 32'h7f;
      svie_pkg::CFG_ICS: m_ics = val & 32'h3ff;
      default: m_icl = val & 32'h3ff;
    endcase
  endtask

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %0s: got %0h want %0h (beat %0d)", what, got, want, n_res);
    n_err++;
  endtask

  // input driver
  always @(negedge clk) begin
    if (rst_n && !(in_valid && !in_fire)) begin
      if (dgap > 0) begin
        dgap--;
        in_valid <= 1'b0;
      end else if (instr_q.size() != 0) begin
        in_data <= instr_q.pop_front();
        in_valid <= 1'b1;
        if (!calm && $urandom_range(0, 5) == 0) dgap = $urandom_range(1, 7);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side stall
  always @(negedge clk) begin
    if (!long_done && n_acc >= 300) begin
      long_done = 1'b1;
      hold = 400;
    end
    if (hold > 0) begin
      hold--;
      out_stall <= 1'b1;
    end else if (sgap > 0) begin
      sgap--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if (!calm && $urandom_range(0, 5) == 0) sgap = $urandom_range(1, 7);
    end
  end

  // monitor
  always @(posedge clk) begin
    svie_pkg::out_t e;
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Regression FAIL");
      $finish;
    end else if (rst_n) begin
      in_fire = in_valid && !in_stall;
      if (in_fire) n_acc++;
      if (out_valid && !out_stall) begin
        n_res++;
        if (exp_res.size() == 0) report("unexpected beat", 64'(out_data), 64'(0));
        else begin
          e = exp_res.pop_front();
          if (out_data.next_address !== e.next_address)
            report("next_address", 64'(out_data.next_address), 64'(e.next_address));
          if (out_data.out_valid !== e.out_valid)
            report("out_valid", 64'(out_data.out_valid), 64'(e.out_valid));
          if (out_data.out_value !== e.out_value)
            report("out_value", 64'(out_data.out_value), 64'(e.out_value));
          if (out_data.halted !== e.halted)
            report("halted", 64'(out_data.halted), 64'(e.halted));
          if (out_data.error_code !== e.error_code)
            report("error_code", 64'(out_data.error_code), 64'(e.error_code));
          if (e.halted) n_halt++;
          if (e.error_code != svie_pkg::ERR_NONE) n_fault++;
          if (e.out_valid) n_outw++;
        end
      end
    end
  end

  initial begin
    int gvc_s [NPHASE] = '{0, 127, 5, 0, 20, 2, 3};
    int ics_s [NPHASE] = '{0, 1023, 100, 0, 1000, 0, 512};
    int icl_s [NPHASE] = '{0, 1023, 4, 1023, 30, 6, 0};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    for (int p = 0; p < NPHASE; p++) begin
      wait (instr_q.size() == 0 && exp_res.size() == 0);
      repeat (50) @(posedge clk);
      cfg_write(svie_pkg::CFG_GVC, gvc_s[p]);
      cfg_write(svie_pkg::CFG_ICS, ics_s[p]);
      cfg_write(svie_pkg::CFG_ICL, icl_s[p]);
      if (p == NPHASE - 1) calm = 1'b1;
      queue_instr(mk(svie_pkg::OP_START, 0, 0));
      if (p == 0) begin
        queue_instr(mk(svie_pkg::OP_LOADI, 32'h7fffffff, 0));
        queue_instr(mk(svie_pkg::OP_LOADI, 32'h80000000, 0));
        queue_instr(mk(svie_pkg::OP_ADD, 0, 0));
        queue_instr(mk(svie_pkg::OP_OUT, 0, 0));
        queue_instr(mk(svie_pkg::OP_LOADI, 32'h80000000, 0));
        queue_instr(mk(svie_pkg::OP_LOADI, 32'hffffffff, 0));
        queue_instr(mk(svie_pkg::OP_DIV, 0, 0));
        queue_instr(mk(svie_pkg::OP_OUT, 0, 0));
        queue_instr(mk(svie_pkg::OP_LOADI, 5, 0));
        queue_instr(mk(svie_pkg::OP_LOADI, 0, 0));
        queue_instr(mk(svie_pkg::OP_DIV, 0, 0));
        queue_instr(mk(svie_pkg::OP_OUT, 0, 0));
        queue_instr(mk(svie_pkg::OP_OUT, 0, 0));
        queue_instr(mk(5'd29, 32'hffffffff, 32'hffffffff));
        queue_instr(mk(5'd31, 0, 0));
        queue_instr(mk(svie_pkg::OP_STI, 0, 0));
        queue_instr(mk(svie_pkg::OP_IN, 0, 32'h80000000));
        queue_instr(mk(svie_pkg::OP_IN, 0, 32'h7fffffff));
        queue_instr(mk(svie_pkg::OP_MULT, 0, 0));
        queue_instr(mk(svie_pkg::OP_NOT, 0, 0));
        queue_instr(mk(svie_pkg::OP_PUSH, 0, 0));
        queue_instr(mk(svie_pkg::OP_POP, 0, 0));
        queue_instr(mk(svie_pkg::OP_CAL, 7, 0));
        queue_instr(mk(svie_pkg::OP_RETURN, 0, 0));
        queue_instr(mk(svie_pkg::OP_BR, 32'hffffffff, 0));
      end
      for (int i = 0; i < 120; i++) begin
        svie_pkg::in_t it;
        do it = rand_instr(); while (touches_unwritten(it));
        queue_instr(it);
      end
    end
    wait (instr_q.size() == 0 && exp_res.size() == 0);
    repeat (60) @(posedge clk);
    if (exp_res.size() != 0) report("results left over", 64'(exp_res.size()), 64'(0));
    $display("%0d instructions over %0d configurations, %0d result beats", n_acc, NPHASE, n_res);
    $display("%0d halts, %0d error results, %0d output words", n_halt, n_fault, n_outw);
    if (n_err == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
